[rtl/ierf_pkg.sv]
// shared types, constants and coefficient table for the inverse error function
package ierf_pkg;

    localparam logic signed [31:0] OUT_MAX = 32'sh7FFF_FFFF;
    localparam logic [27:0] LN2_Q28 = 28'd186065280;
    localparam logic [34:0] T_LIMIT_Q30 = 35'd6576668672;
    localparam int NUM_SQ = 30;
    localparam int NUM_STEPS = 9;

    typedef struct packed {
        logic signed [31:0] a;
        logic [34:0]        tmag;
        logic               wide;
        logic signed [63:0] p;
    } poly_t;

    function automatic logic signed [63:0] coef(input logic wide, input logic [3:0] idx);
        logic signed [63:0] w;
        logic signed [63:0] n;
        w = '0;
        n = '0;
        unique case (idx)
            4'd0:
            begin
                w = '0;
                n = 64'sh175C000 <<< 4;
            end
            4'd1:
            begin
                w = 64'sh14DEB44;
                n = 64'sh133B402 <<< 9;
            end
            4'd2:
            begin
                w = 64'sh1F7C9AE <<< 6;
                n = 64'sh1499232 <<< 12;
            end
            4'd3:
            begin
                w = 64'sh147E512 <<< 12;
                n = 64'sh1E52CD2 <<< 8;
            end
            4'd4:
            begin
                w = 64'sh1DCA7DE <<< 16;
                n = -(64'sh1D70BD0 <<< 17);
            end
            4'd5:
            begin
                w = 64'sh19CAB92 <<< 20;
                n = -(64'sh135BE90 <<< 19);
            end
            4'd6:
            begin
                w = 64'sh18CC0DE <<< 23;
                n = 64'sh12F6400 <<< 23;
            end
            4'd7:
            begin
                w = 64'sh13CA920 <<< 24;
                n = 64'sh17A1E50 <<< 25;
            end
            4'd8:
            begin
                w = -(64'sh10EFF66 <<< 30);
                n = -(64'sh1DB2AEE <<< 29);
            end
            4'd9:
            begin
                w = 64'sh1AE16A4 <<< 31;
                n = 64'sh1C5BF88 <<< 31;
            end
            default:
            begin
                w = '0;
                n = '0;
            end
        endcase
        return wide ? w : n;
    endfunction

endpackage

[rtl/ierf_log.sv]
// front end: 1 - a*a, normalization, base-2 logarithm by squaring, scaling to ln
module ierf_log (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  in_valid,
    input  logic signed [31:0]    argument,
    output logic                  out_valid,
    output ierf_pkg::poly_t       out_data
);

    logic               v0_reg, v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg, v7_reg;
    logic signed [31:0] a0_reg, a1_reg, a2_reg, a3_reg, a4_reg, a5_reg, a6_reg;
    logic [30:0]        am0_reg;
    logic [61:0]        sq1_reg;
    logic [62:0]        u2_reg, u3_reg;
    logic [5:0]         k3_reg, k4_reg;
    logic [31:0]        m4_reg;
    logic [34:0]        lmag5_reg;
    logic [62:0]        prod6_reg;
    ierf_pkg::poly_t    out_reg;

    logic               qv_reg [ierf_pkg::NUM_SQ];
    logic signed [31:0] qa_reg [ierf_pkg::NUM_SQ];
    logic [5:0]         qk_reg [ierf_pkg::NUM_SQ];
    logic [31:0]        qm_reg [ierf_pkg::NUM_SQ];
    logic [29:0]        qf_reg [ierf_pkg::NUM_SQ];

    logic signed [31:0] a0_next;
    logic [5:0]         k3_next;
    logic [5:0]         shamt;
    logic [34:0]        lmag5_next;
    logic [63:0]        rnd;
    logic [34:0]        tmag_next;
    logic               wide_next;

    always_comb
    begin
        a0_next = (argument == 32'sh8000_0000) ? -ierf_pkg::OUT_MAX : argument;
    end

    always_comb
    begin
        k3_next = '0;
        for (int i = 0; i < 63; i++)
        begin
            if (u2_reg[i])
            begin
                k3_next = 6'(i);
            end
        end
    end

    assign shamt = k3_reg - 6'd31;
    assign lmag5_next = (35'(6'd62 - qk_reg[ierf_pkg::NUM_SQ-1]) << 30)
                        - 35'(qf_reg[ierf_pkg::NUM_SQ-1]);
    assign rnd = 64'(prod6_reg) + (64'd1 << 27);
    assign tmag_next = rnd[62:28];
    assign wide_next = tmag_next > ierf_pkg::T_LIMIT_Q30;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
        end
        else if (en)
        begin
            v0_reg <= in_valid;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= qv_reg[ierf_pkg::NUM_SQ-1];
            v6_reg <= v5_reg;
            v7_reg <= v6_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a0_reg    <= a0_next;
            am0_reg   <= a0_next[31] ? 31'(-a0_next) : a0_next[30:0];
            a1_reg    <= a0_reg;
            sq1_reg   <= 62'(am0_reg) * 62'(am0_reg);
            a2_reg    <= a1_reg;
            u2_reg    <= (63'd1 << 62) - 63'(sq1_reg);
            a3_reg    <= a2_reg;
            u3_reg    <= u2_reg;
            k3_reg    <= k3_next;
            a4_reg    <= a3_reg;
            k4_reg    <= k3_reg;
            m4_reg    <= 32'(u3_reg >> shamt);
            a5_reg    <= qa_reg[ierf_pkg::NUM_SQ-1];
            lmag5_reg <= lmag5_next;
            a6_reg    <= a5_reg;
            prod6_reg <= 63'(lmag5_reg) * 63'(ierf_pkg::LN2_Q28);
            out_reg.a    <= a6_reg;
            out_reg.tmag <= tmag_next;
            out_reg.wide <= wide_next;
            out_reg.p    <= ierf_pkg::coef(wide_next, 4'd0);
        end
    end

    for (genvar i = 0; i < ierf_pkg::NUM_SQ; i++)
    begin : g_sq
        logic               v_in;
        logic signed [31:0] a_in;
        logic [5:0]         k_in;
        logic [31:0]        m_in;
        logic [29:0]        f_in;
        logic [63:0]        sq;

        if (i == 0)
        begin : g_first
            assign v_in = v4_reg;
            assign a_in = a4_reg;
            assign k_in = k4_reg;
            assign m_in = m4_reg;
            assign f_in = '0;
        end
        else
        begin : g_rest
            assign v_in = qv_reg[i-1];
            assign a_in = qa_reg[i-1];
            assign k_in = qk_reg[i-1];
            assign m_in = qm_reg[i-1];
            assign f_in = qf_reg[i-1];
        end

        assign sq = 64'(m_in) * 64'(m_in);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                qv_reg[i] <= 1'b0;
            end
            else if (en)
            begin
                qv_reg[i] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                qa_reg[i] <= a_in;
                qk_reg[i] <= k_in;
                qm_reg[i] <= sq[63] ? sq[63:32] : sq[62:31];
                qf_reg[i] <= {f_in[28:0], sq[63]};
            end
        end
    end

    assign out_valid = v7_reg;
    assign out_data  = out_reg;

endmodule

[rtl/ierf_step.sv]
// one horner step: p = round(p*t / 2^30) + c over three stages
module ierf_step (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic [3:0]        step_idx,
    input  logic              in_valid,
    input  ierf_pkg::poly_t   in_data,
    output logic              out_valid,
    output ierf_pkg::poly_t   out_data
);

    logic               v1_reg, v2_reg, v3_reg;
    logic signed [31:0] a1_reg, a2_reg;
    logic [34:0]        t1_reg, t2_reg;
    logic               w1_reg, w2_reg;
    logic               n1_reg, n2_reg;
    logic [63:0]        pm1_reg;
    logic [66:0]        ph2_reg, pl2_reg;
    ierf_pkg::poly_t    out_reg;

    logic [99:0]        full;
    logic [69:0]        sh;
    logic [63:0]        res;
    logic signed [63:0] r;

    assign full = {1'b0, ph2_reg, 32'b0} + 100'(pl2_reg) + (100'd1 << 29);
    assign sh   = full[99:30];
    assign res  = (|sh[69:63]) ? 64'h7FFF_FFFF_FFFF_FFFF : {1'b0, sh[62:0]};
    assign r    = n2_reg ? -$signed(res) : $signed(res);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a1_reg  <= in_data.a;
            t1_reg  <= in_data.tmag;
            w1_reg  <= in_data.wide;
            n1_reg  <= in_data.p[63] ^ (in_data.tmag != '0);
            pm1_reg <= in_data.p[63] ? 64'(-in_data.p) : 64'(in_data.p);
            a2_reg  <= a1_reg;
            t2_reg  <= t1_reg;
            w2_reg  <= w1_reg;
            n2_reg  <= n1_reg;
            ph2_reg <= 67'(pm1_reg[63:32]) * 67'(t1_reg);
            pl2_reg <= 67'(pm1_reg[31:0]) * 67'(t1_reg);
            out_reg.a    <= a2_reg;
            out_reg.tmag <= t2_reg;
            out_reg.wide <= w2_reg;
            out_reg.p    <= r + ierf_pkg::coef(w2_reg, step_idx);
        end
    end

    assign out_valid = v3_reg;
    assign out_data  = out_reg;

endmodule

[rtl/ierf_final.sv]
// final product a*p rounded to q.28 and saturated
module ierf_final (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_valid,
    input  ierf_pkg::poly_t    in_data,
    output logic               out_valid,
    output logic signed [31:0] out_result
);

    logic               v1_reg, v2_reg, v3_reg;
    logic [30:0]        am1_reg;
    logic [63:0]        pm1_reg;
    logic               n1_reg, n2_reg;
    logic [62:0]        ph2_reg, pl2_reg;
    logic signed [31:0] res_reg;

    logic [95:0]        full;
    logic [36:0]        sh;
    logic [31:0]        mag;

    assign full = {1'b0, ph2_reg, 32'b0} + 96'(pl2_reg) + (96'd1 << 58);
    assign sh   = full[95:59];
    assign mag  = (|sh[36:31]) ? 32'(ierf_pkg::OUT_MAX) : {1'b0, sh[30:0]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            am1_reg <= in_data.a[31] ? 31'(-in_data.a) : in_data.a[30:0];
            pm1_reg <= in_data.p[63] ? 64'(-in_data.p) : 64'(in_data.p);
            n1_reg  <= in_data.a[31] ^ in_data.p[63];
            n2_reg  <= n1_reg;
            ph2_reg <= 63'(pm1_reg[63:32]) * 63'(am1_reg);
            pl2_reg <= 63'(pm1_reg[31:0]) * 63'(am1_reg);
            res_reg <= n2_reg ? -$signed(mag) : $signed(mag);
        end
    end

    assign out_valid  = v3_reg;
    assign out_result = res_reg;

endmodule

[rtl/inverse_error_function.sv]
// top level of the inverse error function pipeline
//
// one request on the input channel carries a signed q1.31 argument strictly
// inside (-1,1); the code for exactly -1 is treated as the nearest value above.
// one request on the output channel carries erfinv(argument) scaled by 2^28,
// saturated to +-(2^31-1).
// both channels use valid/ready; a request moves when valid and ready are high.
// a request passes from input acceptance to output valid through 38 stages
// of logarithm (30 of them one squaring each), nine horner steps of three
// stages, three stages of final product, and the output.
// throughput is one request per cycle if unstalled; every stage holds at most
// two 32x35 multiplies side by side and moves together on one shared enable.
// a two-entry output buffer parts the pipeline from the receiver; when the
// receiver stalls the buffer fills and in_ready drops once it holds two, the
// whole pipeline then holds in place and nothing is lost or repeated.
// reset clears all valid bits and the buffer; in_ready is high right after.
module inverse_error_function (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [31:0] argument,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] result
);

    logic               en;
    logic               hv [ierf_pkg::NUM_STEPS+1];
    ierf_pkg::poly_t    hd [ierf_pkg::NUM_STEPS+1];
    logic               fin_valid;
    logic signed [31:0] fin_result;

    logic [1:0]         cnt_reg, cnt_next;
    logic signed [31:0] e0_reg, e0_next, e1_reg, e1_next;
    logic               push, pop;

    assign en       = (cnt_reg != 2'd2);
    assign in_ready = en;

    ierf_log u_log (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (in_valid),
        .argument  (argument),
        .out_valid (hv[0]),
        .out_data  (hd[0])
    );

    for (genvar s = 0; s < ierf_pkg::NUM_STEPS; s++)
    begin : g_step
        ierf_step u_step (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .step_idx  (4'(s + 1)),
            .in_valid  (hv[s]),
            .in_data   (hd[s]),
            .out_valid (hv[s+1]),
            .out_data  (hd[s+1])
        );
    end

    ierf_final u_final (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .in_valid   (hv[ierf_pkg::NUM_STEPS]),
        .in_data    (hd[ierf_pkg::NUM_STEPS]),
        .out_valid  (fin_valid),
        .out_result (fin_result)
    );

    assign push = fin_valid & en;
    assign pop  = (cnt_reg != 2'd0) & out_ready;

    always_comb
    begin
        cnt_next = cnt_reg;
        e0_next  = e0_reg;
        e1_next  = e1_reg;
        priority if (push && pop)
        begin
            if (cnt_reg == 2'd1)
            begin
                e0_next = fin_result;
            end
            else
            begin
                e0_next = e1_reg;
                e1_next = fin_result;
            end
        end
        else if (pop)
        begin
            e0_next  = e1_reg;
            cnt_next = cnt_reg - 2'd1;
        end
        else if (push)
        begin
            if (cnt_reg == 2'd0)
            begin
                e0_next = fin_result;
            end
            else
            begin
                e1_next = fin_result;
            end
            cnt_next = cnt_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        e0_reg <= e0_next;
        e1_reg <= e1_next;
    end

    assign out_valid = (cnt_reg != 2'd0);
    assign result    = e0_reg;

endmodule

[rtl/ierf_checker.sv]
// port-level checks for the inverse error function, bound to the top level
module ierf_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic signed [31:0] argument,
    input logic               out_valid,
    input logic               out_ready,
    input logic signed [31:0] result
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(result))
        else $error("stalled result changed");

    a_ready_low_full: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid)
        else $error("input blocked with no result waiting");

    a_ready_fall: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(in_ready) |-> $past(out_valid && !out_ready))
        else $error("input blocked without a stalled result");

    a_no_min_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> result != 32'sh8000_0000)
        else $error("result outside saturation range");

endmodule

bind inverse_error_function ierf_checker u_ierf_checker (.*);
